@@ rtl/mexp_pkg.sv @@
// package for the modular exponentiation unit
// widths of the item fields, default word width, command codes, reset value of the modulus and the sequencer states
// no dependencies
package mexp_pkg;

  localparam int WORD_BITS_DEF = 64;

  localparam int CMD_W     = 1;
  localparam int BASE_W    = 64;
  localparam int EXP_W     = 63;
  localparam int MODULUS_W = 63;
  localparam int RESIDUE_W = 63;

  localparam logic [MODULUS_W-1:0] MODULUS_RST = MODULUS_W'(1000003);

  localparam logic [CMD_W-1:0] CMD_POWER   = 1'b0;
  localparam logic [CMD_W-1:0] CMD_INVERSE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_FIX,
    ST_LOOP,
    ST_MUL,
    ST_SQR,
    ST_DONE
  } mexp_state_t;

endpackage

@@ rtl/mexp_req_if.sv @@
// input channel of the modular exponentiation unit: command, base and exponent
// depends on mexp_pkg
interface mexp_req_if;
  logic                              valid;
  logic                              ready;
  logic [mexp_pkg::CMD_W-1:0]        cmd;
  logic signed [mexp_pkg::BASE_W-1:0] base_value;
  logic [mexp_pkg::EXP_W-1:0]        exponent;

  modport source (output valid, cmd, base_value, exponent, input ready);
  modport sink   (input valid, cmd, base_value, exponent, output ready);
endinterface

@@ rtl/mexp_rsp_if.sv @@
// result channel of the modular exponentiation unit
// depends on mexp_pkg
interface mexp_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [mexp_pkg::RESIDUE_W-1:0] residue;

  modport source (output valid, residue, input ready);
  modport sink   (input valid, residue, output ready);
endinterface

@@ rtl/mexp_cfg_if.sv @@
// configuration write channel carrying the modulus
// depends on mexp_pkg
interface mexp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mexp_pkg::MODULUS_W-1:0] modulus;

  modport source (output valid, modulus, input ready);
  modport sink   (input valid, modulus, output ready);
endinterface

@@ rtl/mexp_mulmod.sv @@
// shared modular multiplier: (x * y) mod m, one bit of y per cycle, msb first
// operands x and m must hold while busy; y is captured at start
// depends on mexp_pkg
module mexp_mulmod #(
  parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] x,
  input  logic [WORD_BITS-1:0] y,
  input  logic [WORD_BITS-1:0] m,
  output logic                 done,
  output logic [WORD_BITS-1:0] acc
);
  import mexp_pkg::*;

  localparam int CNT_W = $clog2(WORD_BITS);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [WORD_BITS-1:0] ycur;
  logic [WORD_BITS-1:0] dbl;
  logic [WORD_BITS-1:0] red1;
  logic [WORD_BITS-1:0] sum;
  logic [WORD_BITS-1:0] red2;
  logic [WORD_BITS-1:0] acc_next;

  // acc < m < 2^(WORD_BITS-1), so neither the doubling nor the add overflows
  always_comb begin
    dbl      = {acc[WORD_BITS-2:0], 1'b0};
    red1     = (dbl >= m) ? dbl - m : dbl;
    sum      = red1 + x;
    red2     = (sum >= m) ? sum - m : sum;
    acc_next = ycur[WORD_BITS-1] ? red2 : red1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= '0;
      ycur <= y;
      cnt  <= CNT_W'(WORD_BITS - 1);
    end else if (busy) begin
      acc  <= acc_next;
      ycur <= {ycur[WORD_BITS-2:0], 1'b0};
      cnt  <= cnt - 1'b1;
    end
  end

endmodule

@@ rtl/mexp_ctrl.sv @@
// sequencer for square and multiply: reduces the base, walks the exponent bits
// and drives the shared multiplier; holds the result register of the output side
// depends on mexp_pkg, mexp_req_if, mexp_rsp_if, mexp_mulmod
module mexp_ctrl #(
  parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [WORD_BITS-1:0] m,
  mexp_req_if.sink             req,
  mexp_rsp_if.source           rsp
);
  import mexp_pkg::*;

  mexp_state_t          state;
  mexp_state_t          state_next;
  logic [WORD_BITS-2:0] e;
  logic [WORD_BITS-1:0] b;
  logic [WORD_BITS-1:0] r;
  logic                 neg;
  logic                 out_valid;
  logic [RESIDUE_W-1:0] residue;

  logic                 accept;
  logic                 m_small;
  logic                 out_free;
  logic [WORD_BITS-1:0] raw;
  logic [WORD_BITS-1:0] mag;
  logic [WORD_BITS-1:0] m_minus2;
  logic                 mm_start;
  logic [WORD_BITS-1:0] mm_x;
  logic [WORD_BITS-1:0] mm_y;
  logic                 mm_done;
  logic [WORD_BITS-1:0] mm_acc;

  always_comb begin
    raw      = req.base_value[WORD_BITS-1:0];
    mag      = raw[WORD_BITS-1] ? WORD_BITS'(0) - raw : raw;
    m_small  = (m <= WORD_BITS'(1));
    m_minus2 = m - WORD_BITS'(2);
    out_free = !out_valid || rsp.ready;
    accept   = req.valid && req.ready;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = m_small ? ST_DONE : ST_RED;
      end
      ST_RED: begin
        if (mm_done) state_next = ST_FIX;
      end
      ST_FIX: state_next = ST_LOOP;
      ST_LOOP: begin
        if (e == '0) state_next = ST_DONE;
        else if (e[0]) state_next = ST_MUL;
        else state_next = ST_SQR;
      end
      ST_MUL: begin
        if (mm_done) state_next = ST_SQR;
      end
      ST_SQR: begin
        if (mm_done) state_next = ST_LOOP;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req.ready = 1'b0;
    mm_start  = 1'b0;
    mm_x      = b;
    mm_y      = b;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        mm_start  = req.valid && !m_small;
        mm_y      = mag;
      end
      ST_RED:  mm_x = WORD_BITS'(1);
      ST_LOOP: mm_start = (e != '0);
      ST_MUL: begin
        mm_x     = r;
        mm_start = mm_done;
      end
      default: begin
        mm_x = b;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && out_free) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          neg <= raw[WORD_BITS-1];
          r   <= '0;
          e   <= (req.cmd == CMD_INVERSE) ? m_minus2[WORD_BITS-2:0]
                                          : req.exponent[WORD_BITS-2:0];
        end
      end
      ST_RED: begin
        if (mm_done) b <= mm_acc;
      end
      ST_FIX: begin
        // a negative base lands on m - (|base| mod m), or zero
        if (neg && b != '0) b <= m - b;
        r <= WORD_BITS'(1);
      end
      ST_MUL: begin
        if (mm_done) r <= mm_acc;
      end
      ST_SQR: begin
        if (mm_done) begin
          b <= mm_acc;
          e <= e >> 1;
        end
      end
      ST_DONE: begin
        if (out_free) residue <= RESIDUE_W'(r);
      end
      default: begin
        neg <= neg;
      end
    endcase
  end

  assign rsp.valid   = out_valid;
  assign rsp.residue = residue;

  mexp_mulmod #(
    .WORD_BITS(WORD_BITS)
  ) u_mulmod (
    .clk  (clk),
    .rst  (rst),
    .start(mm_start),
    .x    (mm_x),
    .y    (mm_y),
    .m    (m),
    .done (mm_done),
    .acc  (mm_acc)
  );

endmodule

@@ rtl/modular_exponentiation_unit.sv @@
// top level of the modular exponentiation unit: modulus register, sequencer
// depends on mexp_pkg, mexp_req_if, mexp_rsp_if, mexp_cfg_if, mexp_ctrl

// Computes base_value ^ exponent mod modulus (cmd = 1: base_value ^ (modulus - 2),
// the inverse for a prime modulus) by right-to-left square and multiply. The signed
// base is first brought into 0 .. modulus-1; a modulus of 0 or 1 gives 0. All work is
// done by one modular multiplier that retires one bit of its multiplier per cycle.
// The unit takes one item at a time; a finished result waits in the output register
// while the next item is taken. The modulus is written over the configuration
// channel, which is always ready; the user must write it only while no item is
// in flight, since the block itself does not enforce this.
module modular_exponentiation_unit #(
  parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  mexp_req_if.sink   req,
  mexp_rsp_if.source rsp,
  mexp_cfg_if.sink   cfg
);
  import mexp_pkg::*;

  logic [MODULUS_W-1:0] modulus;
  logic [WORD_BITS-1:0] m;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RST;
    end else if (cfg.valid) begin
      modulus <= cfg.modulus;
    end
  end

  assign m = {1'b0, modulus[WORD_BITS-2:0]};

  mexp_ctrl #(
    .WORD_BITS(WORD_BITS)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .m  (m),
    .req(req),
    .rsp(rsp)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("unit ready right after taking an item");

  a_residue_in_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (m > WORD_BITS'(1)) |-> (WORD_BITS'(rsp.residue) < m))
    else $error("residue not below modulus");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(!req.ready))
    else $error("result shown without a finished item");
`endif

endmodule
